// ===== rtl/core/vphd_pkg.sv =====
// Shared types and constants for the video payload header decoder.
package vphd_pkg;

   // Field widths fixed by the channel definitions
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 12;
   localparam int CAP_W      = 24;
   localparam int SEQ_W      = 16;
   localparam int MIN_HEADER = 2;

   // Saturation point of the byte counter
   localparam logic [LEN_W-1:0] POS_MAX = '1;

   // Header flag bit positions
   localparam int FLAG_FID_BIT = 0;
   localparam int FLAG_EOF_BIT = 1;
   localparam int FLAG_ERR_BIT = 6;

   // Packet status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [1:0] STATUS_ERROR      = 2'd2;

   // Per-packet state, cleared at packet end
   typedef struct packed {
      logic [LEN_W-1:0]  byte_position;
      logic [BYTE_W-1:0] header_length;
      logic [1:0]        packet_state;
      logic              eof_seen;
      logic              new_frame_seen;
   } pkt_state_type;

   // Per-frame state, kept across packets
   typedef struct packed {
      logic             previous_frame_id;
      logic             frame_id_known;
      logic [SEQ_W-1:0] sequence_count;
      logic             overflow_seen;
   } frm_state_type;

   // One result item
   typedef struct packed {
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic [CAP_W-1:0]  write_offset;
      logic              packet_done;
      logic [1:0]        packet_status;
      logic              new_frame;
      logic              frame_end;
      logic [SEQ_W-1:0]  frame_sequence;
      logic [CAP_W-1:0]  frame_bytes;
      logic              overflow;
   } result_type;

endpackage

// ===== rtl/core/vphd_if.sv =====
// Channel interfaces: byte input, result output and capacity register write.
interface vphd_req_if;
   import vphd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  packet_length;
   logic              last_in_packet;

   modport source (output valid, payload_byte, packet_length, last_in_packet, input ready);
   modport sink   (input valid, payload_byte, packet_length, last_in_packet, output ready);
endinterface

interface vphd_rsp_if;
   import vphd_pkg::*;
   logic              valid;
   logic              ready;
   logic              data_valid;
   logic [BYTE_W-1:0] data_byte;
   logic [CAP_W-1:0]  write_offset;
   logic              packet_done;
   logic [1:0]        packet_status;
   logic              new_frame;
   logic              frame_end;
   logic [SEQ_W-1:0]  frame_sequence;
   logic [CAP_W-1:0]  frame_bytes;
   logic              overflow;

   modport source (output valid, data_valid, data_byte, write_offset, packet_done,
                   packet_status, new_frame, frame_end, frame_sequence, frame_bytes,
                   overflow, input ready);
   modport sink   (input valid, data_valid, data_byte, write_offset, packet_done,
                   packet_status, new_frame, frame_end, frame_sequence, frame_bytes,
                   overflow, output ready);
endinterface

interface vphd_csr_if;
   import vphd_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/vphd_step.sv =====
// Combinational decode of one packet byte: next state and the result item.
module vphd_step
   import vphd_pkg::*;
#(
   parameter int MAX_PACKET_BYTES  = 3072,
   parameter int FRAME_OFFSET_BITS = 24
) (
   input  pkt_state_type                pkt_cur,
   input  frm_state_type                frm_cur,
   input  logic [FRAME_OFFSET_BITS-1:0] fill_cur,
   input  logic [CAP_W-1:0]             capacity,
   input  logic [BYTE_W-1:0]            payload_byte,
   input  logic [LEN_W-1:0]             packet_length,
   input  logic                         last_in_packet,
   output pkt_state_type                pkt_nxt,
   output frm_state_type                frm_nxt,
   output logic [FRAME_OFFSET_BITS-1:0] fill_nxt,
   output result_type                   result
);

   localparam int CMP_W = (FRAME_OFFSET_BITS > CAP_W) ? FRAME_OFFSET_BITS : CAP_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_BYTES);

   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  hdr_len;
   logic [LEN_W-1:0]  pos;
   logic              hdr_bad;
   logic              fid;
   logic              emit;
   logic [CMP_W-1:0]  fill_ext;
   logic [CMP_W-1:0]  cap_ext;
   logic [CMP_W-1:0]  off_ext;
   logic [1:0]        status;

   // Length clamp and header checks
   assign len     = (packet_length > MAX_LEN) ? MAX_LEN : packet_length;
   assign hdr_len = LEN_W'(pkt_cur.header_length);
   assign pos     = pkt_cur.byte_position;
   assign hdr_bad = (len < LEN_W'(MIN_HEADER)) || (hdr_len < LEN_W'(MIN_HEADER)) ||
                    (hdr_len > len);
   assign fid     = payload_byte[FLAG_FID_BIT];
   assign fill_ext = CMP_W'(fill_cur);
   assign cap_ext  = CMP_W'(capacity);

   // State update for header and payload bytes
   always_comb begin
      pkt_nxt = pkt_cur;
      frm_nxt = frm_cur;
      fill_nxt = fill_cur;
      emit = 1'b0;
      if (pos == '0) begin
         pkt_nxt.header_length = payload_byte;
      end else if (pos == LEN_W'(1)) begin
         if (hdr_bad) begin
            pkt_nxt.packet_state = STATUS_BAD_HEADER;
         end else begin
            if (!frm_cur.frame_id_known || (frm_cur.previous_frame_id != fid)) begin
               frm_nxt.sequence_count = frm_cur.sequence_count + SEQ_W'(1);
               fill_nxt = '0;
               frm_nxt.overflow_seen = 1'b0;
               pkt_nxt.new_frame_seen = 1'b1;
            end
            if (payload_byte[FLAG_ERR_BIT]) begin
               fill_nxt = '0;
               frm_nxt.overflow_seen = 1'b0;
               pkt_nxt.packet_state = STATUS_ERROR;
            end else begin
               frm_nxt.previous_frame_id = fid;
               frm_nxt.frame_id_known = 1'b1;
               pkt_nxt.eof_seen = payload_byte[FLAG_EOF_BIT];
            end
         end
      end else if ((pkt_cur.packet_state == STATUS_OK) && (pos >= hdr_len) && (pos < len)) begin
         if (fill_ext >= cap_ext) begin
            frm_nxt.overflow_seen = 1'b1;
         end else begin
            emit = 1'b1;
            fill_nxt = fill_cur + FRAME_OFFSET_BITS'(1);
         end
      end

      // Packet end clears per-packet state, otherwise count the byte
      if (last_in_packet) begin
         pkt_nxt = '0;
      end else if (pos != POS_MAX) begin
         pkt_nxt.byte_position = pos + LEN_W'(1);
      end
   end

   // Result item; a packet ending on byte 0 is a bad header
   assign status  = ((pos == '0) || ((pos == LEN_W'(1)) && hdr_bad)) ? STATUS_BAD_HEADER :
                    ((pos == LEN_W'(1)) && payload_byte[FLAG_ERR_BIT]) ? STATUS_ERROR :
                    pkt_cur.packet_state;
   assign off_ext = fill_ext;

   always_comb begin
      logic eof_now;
      logic nf_now;
      logic [CMP_W-1:0] fill_out;
      eof_now  = pkt_cur.eof_seen;
      nf_now   = pkt_cur.new_frame_seen;
      fill_out = CMP_W'(fill_nxt);
      if (pos == LEN_W'(1) && !hdr_bad) begin
         nf_now = pkt_cur.new_frame_seen ||
                  !frm_cur.frame_id_known || (frm_cur.previous_frame_id != fid);
         if (!payload_byte[FLAG_ERR_BIT]) begin
            eof_now = payload_byte[FLAG_EOF_BIT];
         end
      end
      result.data_valid     = emit;
      result.data_byte      = emit ? payload_byte : '0;
      result.write_offset   = emit ? off_ext[CAP_W-1:0] : '0;
      result.packet_done    = last_in_packet;
      result.packet_status  = last_in_packet ? status : STATUS_OK;
      result.new_frame      = last_in_packet && nf_now;
      result.frame_end      = last_in_packet && (status == STATUS_OK) && eof_now;
      result.frame_sequence = frm_nxt.sequence_count;
      result.frame_bytes    = fill_out[CAP_W-1:0];
      result.overflow       = frm_nxt.overflow_seen;
   end

endmodule

// ===== rtl/core/video_payload_header_decoder.sv =====
// Top level of the video payload header decoder.
// The result of a byte transfer is registered and offered on the result side until it is taken.
// Throughput: one byte per cycle unless the result side stalls; the state update and result register close in one pass.
// A full result register stalls input only when the result side is not ready.
// Synchronous reset clears packet and frame state (sequence count to all ones) and sets capacity to all ones.
module video_payload_header_decoder
   import vphd_pkg::*;
#(
   parameter int MAX_PACKET_BYTES  = 3072,
   parameter int FRAME_OFFSET_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   vphd_req_if.sink     req_if,
   vphd_rsp_if.source   rsp_if,
   vphd_csr_if.sink     csr_if
);

   pkt_state_type                pkt_ff;
   pkt_state_type                pkt_in;
   frm_state_type                frm_ff;
   frm_state_type                frm_in;
   logic [FRAME_OFFSET_BITS-1:0] fill_ff;
   logic [FRAME_OFFSET_BITS-1:0] fill_in;
   logic [CAP_W-1:0]             capacity_ff;
   result_type                   result_ff;
   result_type                   result_in;
   logic                         rsp_valid_ff;
   logic                         req_take;

   // Input is taken whenever the result register is free or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   vphd_step #(
      .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
      .FRAME_OFFSET_BITS (FRAME_OFFSET_BITS)
   ) u_step (
      .pkt_cur        (pkt_ff),
      .frm_cur        (frm_ff),
      .fill_cur       (fill_ff),
      .capacity       (capacity_ff),
      .payload_byte   (req_if.payload_byte),
      .packet_length  (req_if.packet_length),
      .last_in_packet (req_if.last_in_packet),
      .pkt_nxt        (pkt_in),
      .frm_nxt        (frm_in),
      .fill_nxt       (fill_in),
      .result         (result_in)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff       <= '0;
         frm_ff       <= '{previous_frame_id: 1'b0, frame_id_known: 1'b0,
                           sequence_count: '1, overflow_seen: 1'b0};
         fill_ff      <= '0;
         capacity_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            capacity_ff <= csr_if.data;
         end
         if (req_take) begin
            pkt_ff  <= pkt_in;
            frm_ff  <= frm_in;
            fill_ff <= fill_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   // Result transfer
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.data_valid     = result_ff.data_valid;
   assign rsp_if.data_byte      = result_ff.data_byte;
   assign rsp_if.write_offset   = result_ff.write_offset;
   assign rsp_if.packet_done    = result_ff.packet_done;
   assign rsp_if.packet_status  = result_ff.packet_status;
   assign rsp_if.new_frame      = result_ff.new_frame;
   assign rsp_if.frame_end      = result_ff.frame_end;
   assign rsp_if.frame_sequence = result_ff.frame_sequence;
   assign rsp_if.frame_bytes    = result_ff.frame_bytes;
   assign rsp_if.overflow       = result_ff.overflow;

endmodule

// ===== bench/vphd_result_checker.sv =====
// Result checker for the video payload header decoder: predicts every result and compares it.
module vphd_result_checker
   import vphd_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 3072
) (
   input  logic clock,
   input  logic reset,
   vphd_req_if  req_mon,
   vphd_rsp_if  rsp_mon,
   vphd_csr_if  csr_mon,
   output int   mismatch_count,
   output int   results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Capacity register copy
   logic [CAP_W-1:0]  frame_cap;

   // Packet state
   logic [LEN_W-1:0]  pos;
   logic [BYTE_W-1:0] hdr_len;
   logic [1:0]        pkt_status;
   logic              eof_flag;
   logic              nf_flag;

   // Frame state
   logic              prev_fid;
   logic              fid_valid;
   logic [CAP_W-1:0]  fill;
   logic [SEQ_W-1:0]  seq_count;
   logic              ovf_flag;

   result_type        predicted_rsp[$];
   result_type        got;
   result_type        want;
   int                rsp_count;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, rsp_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] dut_val,
                              input logic [31:0] exp_val);
      if (dut_val !== exp_val)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, dut_val, exp_val));
   endtask

   // Decode one packet byte: updates packet and frame state, returns its result
   function automatic result_type decode_byte(input logic [BYTE_W-1:0] b,
                                              input logic [LEN_W-1:0] len_in,
                                              input logic last);
      result_type       r;
      logic [LEN_W-1:0] len;
      r   = '0;
      len = (len_in > MAX_PACKET_BYTES) ? LEN_W'(MAX_PACKET_BYTES) : len_in;

      if (pos == 0) begin
         hdr_len = b;
      end else if (pos == 1) begin
         // header check happens on the flags byte
         if (len < MIN_HEADER || hdr_len < MIN_HEADER || hdr_len > len) begin
            pkt_status = STATUS_BAD_HEADER;
         end else begin
            if (!fid_valid || prev_fid != b[FLAG_FID_BIT]) begin
               seq_count = seq_count + 1'b1;
               fill      = '0;
               ovf_flag  = 1'b0;
               nf_flag   = 1'b1;
            end
            if (b[FLAG_ERR_BIT]) begin
               // error discards the frame; id is not recorded
               fill       = '0;
               ovf_flag   = 1'b0;
               pkt_status = STATUS_ERROR;
            end else begin
               prev_fid  = b[FLAG_FID_BIT];
               fid_valid = 1'b1;
               eof_flag  = b[FLAG_EOF_BIT];
            end
         end
      end else if (pkt_status == STATUS_OK && pos >= hdr_len && pos < len) begin
         // payload byte, dropped once capacity is reached
         if (fill >= frame_cap) begin
            ovf_flag = 1'b1;
         end else begin
            r.data_valid   = 1'b1;
            r.data_byte    = b;
            r.write_offset = fill;
            fill           = fill + 1'b1;
         end
      end

      if (last) begin
         r.packet_status = (pos == 0) ? STATUS_BAD_HEADER : pkt_status;
         r.new_frame     = nf_flag;
         r.frame_end     = (r.packet_status == STATUS_OK) && eof_flag;
      end
      r.packet_done    = last;
      r.frame_sequence = seq_count;
      r.frame_bytes    = fill;
      r.overflow       = ovf_flag;

      // packet end clears per-packet state; position saturates otherwise
      if (last) begin
         pos        = '0;
         hdr_len    = '0;
         pkt_status = STATUS_OK;
         eof_flag   = 1'b0;
         nf_flag    = 1'b0;
      end else if (pos != POS_MAX) begin
         pos = pos + 1'b1;
      end
      return r;
   endfunction

   // Watch transfers on all three channels
   always @(posedge clock) begin
      if (reset) begin
         frame_cap  = '1;
         pos        = '0;
         hdr_len    = '0;
         pkt_status = STATUS_OK;
         eof_flag   = 1'b0;
         nf_flag    = 1'b0;
         prev_fid   = 1'b0;
         fid_valid  = 1'b0;
         fill       = '0;
         seq_count  = '1;
         ovf_flag   = 1'b0;
         rsp_count  = 0;
         predicted_rsp.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            frame_cap = csr_mon.data;

         if (req_mon.valid && req_mon.ready)
            predicted_rsp.push_back(decode_byte(req_mon.payload_byte, req_mon.packet_length,
                                                req_mon.last_in_packet));

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("result transfer with no prediction waiting");
            end else begin
               want = predicted_rsp.pop_front();
               got.data_valid     = rsp_mon.data_valid;
               got.data_byte      = rsp_mon.data_byte;
               got.write_offset   = rsp_mon.write_offset;
               got.packet_done    = rsp_mon.packet_done;
               got.packet_status  = rsp_mon.packet_status;
               got.new_frame      = rsp_mon.new_frame;
               got.frame_end      = rsp_mon.frame_end;
               got.frame_sequence = rsp_mon.frame_sequence;
               got.frame_bytes    = rsp_mon.frame_bytes;
               got.overflow       = rsp_mon.overflow;
               check_field("data_valid",     32'(got.data_valid),     32'(want.data_valid));
               check_field("data_byte",      32'(got.data_byte),      32'(want.data_byte));
               check_field("write_offset",   32'(got.write_offset),   32'(want.write_offset));
               check_field("packet_done",    32'(got.packet_done),    32'(want.packet_done));
               check_field("packet_status",  32'(got.packet_status),  32'(want.packet_status));
               check_field("new_frame",      32'(got.new_frame),      32'(want.new_frame));
               check_field("frame_end",      32'(got.frame_end),      32'(want.frame_end));
               check_field("frame_sequence", 32'(got.frame_sequence),
                           32'(want.frame_sequence));
               check_field("frame_bytes",    32'(got.frame_bytes),    32'(want.frame_bytes));
               check_field("overflow",       32'(got.overflow),       32'(want.overflow));
            end
            rsp_count++;
         end
      end
      results_pending <= predicted_rsp.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the video payload header decoder: clock, reset, stimulus and verdict.
module tb_top
   import vphd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 10;
   localparam int MAX_PKT    = 3072;
   localparam int IDLE_PCT   = 14;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;     // no idling on either side while set
   logic cur_fid = 1'b0;
   int   items_sent = 0;
   int   mismatch_count;
   int   results_pending;

   vphd_req_if req_ch();
   vphd_rsp_if rsp_ch();
   vphd_csr_if csr_ch();

   video_payload_header_decoder #(
      .MAX_PACKET_BYTES  (MAX_PKT),
      .FRAME_OFFSET_BITS (CAP_W)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   vphd_result_checker #(
      .MAX_PACKET_BYTES (MAX_PKT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_mon         (csr_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Result side stalls at random
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
                            input logic last);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.payload_byte   <= b;
      req_ch.packet_length  <= len;
      req_ch.last_in_packet <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] flags,
                              input logic [LEN_W-1:0] len, input int count);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < count; i++) begin
         b = (i == 0) ? hdr : (i == 1) ? flags : BYTE_W'($urandom);
         send_byte(b, len, i == count - 1);
      end
   endtask

   // Stop sending until every predicted result has been checked
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (results_pending == 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain();
      repeat (3) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly well-formed packets with random content, some malformed noise
   task automatic run_random(input int n_items);
      int                stop_at;
      int                kind;
      int                count;
      int                hdr_max;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] hdr;
      logic [BYTE_W-1:0] flags;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 85) begin
            len     = LEN_W'($urandom_range(2, 40));
            hdr_max = (len > 12) ? 12 : len;
            hdr     = BYTE_W'($urandom_range(2, hdr_max));
            if ($urandom_range(99) < 60)
               cur_fid = ~cur_fid;
            flags               = BYTE_W'($urandom);
            flags[FLAG_FID_BIT] = cur_fid;
            flags[FLAG_EOF_BIT] = ($urandom_range(99) < 30);
            flags[FLAG_ERR_BIT] = ($urandom_range(99) < 5);
            count = len;
            kind  = $urandom_range(99);
            if (kind < 8)
               count = $urandom_range(1, len);        // early end
            else if (kind < 14)
               count = len + $urandom_range(1, 6);    // bytes past the length
         end else begin
            len   = LEN_W'($urandom_range(0, 4095));
            hdr   = BYTE_W'($urandom);
            flags = BYTE_W'($urandom);
            count = $urandom_range(1, 6);
         end
         send_packet(hdr, flags, len, count);
         if ($urandom_range(99) < 2)
            drain();
      end
   endtask

   // Stimulus and verdict
   initial begin
      req_ch.valid          = 1'b0;
      req_ch.payload_byte   = '0;
      req_ch.packet_length  = '0;
      req_ch.last_in_packet = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.data           = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed packets at the reset capacity
      send_packet(8'd2, 8'h00, 12'd4, 4);        // first packet opens a frame
      send_packet(8'hFF, 8'h00, 12'd1, 1);       // one-byte packet
      send_packet(8'd1, 8'h01, 12'd3, 3);        // header length below minimum
      send_packet(8'd5, 8'h01, 12'd3, 3);        // header longer than packet
      send_packet(8'd2, 8'h01, 12'd0, 2);        // zero packet length
      send_packet(8'd2, 8'h41, 12'd3, 3);        // error flag
      send_packet(8'd2, 8'h01, 12'd3, 3);        // same id after error: new frame
      send_packet(8'd2, 8'h03, 12'd4095, 3);     // end of frame, oversized length, early end
      send_packet(8'd3, 8'hBC, 12'd4, 5);        // toggled id, bytes past the length
      cur_fid = 1'b0;

      run_random(350);

      // Zero capacity: every payload byte overflows
      write_capacity('0);
      run_random(250);

      // Small capacity with a stretch of back-to-back transfers
      write_capacity(CAP_W'($urandom_range(8, 48)));
      run_random(120);
      steady = 1'b1;
      run_random(220);
      steady = 1'b0;

      // Full capacity; one long packet with an oversized length
      write_capacity('1);
      cur_fid = ~cur_fid;
      send_packet(8'd2, {7'd0, cur_fid}, 12'd4095, 300);
      run_random(220);

      write_capacity(CAP_W'($urandom_range(49, 16777214)));
      run_random(220);

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== video_payload_header_decoder.f =====
rtl/core/vphd_pkg.sv
rtl/core/vphd_if.sv
rtl/core/vphd_step.sv
rtl/core/video_payload_header_decoder.sv
bench/vphd_result_checker.sv
bench/tb_top.sv
